[rtl/iau_pkg.sv]
// ----------------------------------------------------------------------------
// iau_pkg
// Shared opcodes, sequencer states and control beat for the integer
// arithmetic unit.
// ----------------------------------------------------------------------------
package iau_pkg;

   // default operand width
   localparam int WIDTH_DEF = 64;

   // request opcodes
   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_MUL = 4'd1,
      OP_NEG = 4'd2,
      OP_DIV = 4'd3,
      OP_LTU = 4'd4,
      OP_GTU = 4'd5,
      OP_GEU = 4'd6,
      OP_EQ  = 4'd7,
      OP_LTS = 4'd8
   } opcode_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // control from sequencer to datapath
   typedef struct packed {
      logic load;   // capture request beat
      logic step;   // one pass through the shared adder
      logic emit;   // move working result into output register
   } ctrl_type;

endpackage

[rtl/iau_adder.sv]
// ----------------------------------------------------------------------------
// iau_adder
// Shared adder used by every operation, one pass per cycle.
// ----------------------------------------------------------------------------
module iau_adder #(
   parameter int WIDTH = iau_pkg::WIDTH_DEF
) (
   input  logic [WIDTH:0]   x,
   input  logic [WIDTH:0]   y,
   input  logic             cin,
   output logic [WIDTH+1:0] sum
);
   import iau_pkg::*;

   // extended sum, top bit is carry out
   assign sum = {1'b0, x} + {1'b0, y} + {{(WIDTH+1){1'b0}}, cin};

endmodule

[rtl/iau_datapath.sv]
// ----------------------------------------------------------------------------
// iau_datapath
// Working registers, operand steering around the shared adder, and the
// output register.
// ----------------------------------------------------------------------------
module iau_datapath #(
   parameter int WIDTH = iau_pkg::WIDTH_DEF
) (
   input  logic                clock,
   input  iau_pkg::ctrl_type   ctrl,
   input  logic [3:0]          req_type,
   input  logic [WIDTH-1:0]    req_operand_a,
   input  logic [WIDTH-1:0]    req_operand_b,
   input  logic                req_carry_in,
   output logic [WIDTH-1:0]    rsp_result_value,
   output logic [WIDTH-1:0]    rsp_remainder_value,
   output logic                rsp_carry_flag,
   output logic                rsp_compare_true,
   output logic                rsp_divide_by_zero
);
   import iau_pkg::*;

   localparam logic [WIDTH-1:0] TOP_BIT = {1'b1, {(WIDTH-1){1'b0}}};

   logic [3:0]       op_ff;
   logic [WIDTH-1:0] a_ff, b_ff, hi_ff, lo_ff;
   logic             cin_ff, flag_ff, dz_ff;
   logic [WIDTH-1:0] hi_in, lo_in;
   logic             flag_in;

   logic [WIDTH:0]   add_x, add_y;
   logic             add_c;
   logic [WIDTH+1:0] add_sum;
   logic [WIDTH-1:0] a_cmp, b_cmp;
   logic             ge, zero;

   logic [WIDTH-1:0] res_in, rem_in;
   logic             carry_in_o, cmp_in_o, dz_in_o;

   // signed compare maps to unsigned by flipping the sign bits
   assign a_cmp = (op_ff == OP_LTS) ? (a_ff ^ TOP_BIT) : a_ff;
   assign b_cmp = (op_ff == OP_LTS) ? (b_ff ^ TOP_BIT) : b_ff;

   // operand steering into the shared adder
   always_comb begin
      add_x = '0;
      add_y = '0;
      add_c = 1'b0;
      unique case (op_ff)
         OP_ADD: begin
            add_x = {1'b0, a_ff};
            add_y = {1'b0, b_ff};
            add_c = cin_ff;
         end
         OP_NEG: begin
            add_x = {1'b0, ~a_ff};
            add_c = 1'b1;
         end
         OP_MUL: begin
            add_x = {1'b0, hi_ff};
            add_y = lo_ff[0] ? {1'b0, a_ff} : '0;
         end
         OP_DIV: begin
            add_x = {hi_ff, lo_ff[WIDTH-1]};
            add_y = ~{1'b0, b_ff};
            add_c = 1'b1;
         end
         OP_LTU, OP_GTU, OP_GEU, OP_EQ, OP_LTS: begin
            add_x = {1'b0, a_cmp};
            add_y = ~{1'b0, b_cmp};
            add_c = 1'b1;
         end
         default: begin
            add_x = '0;
         end
      endcase
   end

   iau_adder #(.WIDTH(WIDTH)) u_adder (
      .x   (add_x),
      .y   (add_y),
      .cin (add_c),
      .sum (add_sum)
   );

   // no borrow means x >= y for subtract passes
   assign ge   = add_sum[WIDTH+1];
   assign zero = (add_sum[WIDTH-1:0] == '0);

   // next working state for one step
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      flag_in = flag_ff;
      unique case (op_ff)
         OP_ADD: begin
            hi_in   = add_sum[WIDTH-1:0];
            flag_in = add_sum[WIDTH];
         end
         OP_NEG: hi_in = add_sum[WIDTH-1:0];
         OP_MUL: begin
            hi_in = add_sum[WIDTH:1];
            lo_in = {add_sum[0], lo_ff[WIDTH-1:1]};
         end
         OP_DIV: begin
            hi_in = ge ? add_sum[WIDTH-1:0] : add_x[WIDTH-1:0];
            lo_in = {lo_ff[WIDTH-2:0], ge};
         end
         OP_LTU: flag_in = ~ge;
         OP_GTU: flag_in = ge & ~zero;
         OP_GEU: flag_in = ge;
         OP_EQ:  flag_in = zero;
         OP_LTS: flag_in = ~ge;
         default: flag_in = 1'b0;
      endcase
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff   <= req_type;
         a_ff    <= req_operand_a;
         b_ff    <= req_operand_b;
         cin_ff  <= req_carry_in;
         hi_ff   <= '0;
         lo_ff   <= (req_type == OP_MUL) ? req_operand_b : req_operand_a;
         flag_ff <= 1'b0;
         dz_ff   <= (req_type == OP_DIV) && (req_operand_b == '0);
      end else if (ctrl.step) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         flag_ff <= flag_in;
      end
   end

   // result beat assembly
   always_comb begin
      res_in     = '0;
      rem_in     = '0;
      carry_in_o = 1'b0;
      cmp_in_o   = 1'b0;
      dz_in_o    = 1'b0;
      unique case (op_ff)
         OP_ADD: begin
            res_in     = hi_ff;
            carry_in_o = flag_ff;
         end
         OP_NEG: res_in = hi_ff;
         OP_MUL: begin
            res_in     = lo_ff;
            carry_in_o = |hi_ff;
         end
         OP_DIV: begin
            if (dz_ff) begin
               dz_in_o = 1'b1;
            end else begin
               res_in = lo_ff;
               rem_in = hi_ff;
            end
         end
         OP_LTU, OP_GTU, OP_GEU, OP_EQ, OP_LTS: cmp_in_o = flag_ff;
         default: res_in = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_result_value    <= res_in;
         rsp_remainder_value <= rem_in;
         rsp_carry_flag      <= carry_in_o;
         rsp_compare_true    <= cmp_in_o;
         rsp_divide_by_zero  <= dz_in_o;
      end
   end

endmodule

[rtl/iau_seq.sv]
// ----------------------------------------------------------------------------
// iau_seq
// Sequencer: request handshake, step counter and result valid.
// ----------------------------------------------------------------------------
module iau_seq #(
   parameter int WIDTH = iau_pkg::WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_type,
   input  logic              req_b_zero,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iau_pkg::ctrl_type ctrl
);
   import iau_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             multi_ff, multi_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, out_busy;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state and control
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      multi_in     = multi_ff;
      ctrl         = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               cnt_in    = '0;
               multi_in  = (req_type == OP_MUL) || (req_type == OP_DIV);
               state_in  = ((req_type == OP_DIV) && req_b_zero) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            if (!multi_ff || (cnt_ff == CNT_LAST)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               ctrl.emit    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         multi_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         multi_ff     <= multi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // an accepted beat always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("iau_seq: idle after accepted request");

   // result register never overwritten while held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !out_busy)
      else $error("iau_seq: result overwritten while stalled");

   // single pass operations finish after one step
   a_single_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && !multi_ff) |=> (state_ff == ST_DONE))
      else $error("iau_seq: single step operation did not finish");

   // load, step and emit are exclusive
   a_ctrl_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.step, ctrl.emit}))
      else $error("iau_seq: conflicting datapath controls");
`endif

endmodule

[rtl/integer_arith_unit.sv]
// ----------------------------------------------------------------------------
// integer_arith_unit
// Add, multiply, negate, divide and compare over one shared adder.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_stall    req_type, req_operand_a,
//                                              req_operand_b, req_carry_in
//   rsp      out        rsp_valid/rsp_stall    rsp_result_value,
//                                              rsp_remainder_value, flags
//
// Add, negate and compares: one adder pass between accept and result valid.
// Multiply and divide: one adder pass per operand bit.
// Divide by zero: no adder pass. One request in flight; req_stall is high
// from accept until the result is loaded into the output register.
// A stalled result only holds the last sequencer state; reset is
// synchronous and clears control state only.
// ----------------------------------------------------------------------------
module integer_arith_unit #(
   parameter int WIDTH = iau_pkg::WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [3:0]       req_type,
   input  logic [WIDTH-1:0] req_operand_a,
   input  logic [WIDTH-1:0] req_operand_b,
   input  logic             req_carry_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_result_value,
   output logic [WIDTH-1:0] rsp_remainder_value,
   output logic             rsp_carry_flag,
   output logic             rsp_compare_true,
   output logic             rsp_divide_by_zero
);
   import iau_pkg::*;

   ctrl_type ctrl;
   logic     b_zero;

   assign b_zero = (req_operand_b == '0);

   // sequencer
   iau_seq #(.WIDTH(WIDTH)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_b_zero (b_zero),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .ctrl       (ctrl)
   );

   // datapath around the shared adder
   iau_datapath #(.WIDTH(WIDTH)) u_datapath (
      .clock               (clock),
      .ctrl                (ctrl),
      .req_type            (req_type),
      .req_operand_a       (req_operand_a),
      .req_operand_b       (req_operand_b),
      .req_carry_in        (req_carry_in),
      .rsp_result_value    (rsp_result_value),
      .rsp_remainder_value (rsp_remainder_value),
      .rsp_carry_flag      (rsp_carry_flag),
      .rsp_compare_true    (rsp_compare_true),
      .rsp_divide_by_zero  (rsp_divide_by_zero)
   );

endmodule
